### src/fpau_pkg.sv
`default_nettype none

package fpau_pkg;

   localparam int VALUE_W = 32;
   localparam int WIDE_W  = 64;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_MUL     = 2'd1;
   localparam logic [1:0] OP_REQUANT = 2'd2;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [VALUE_W-1:0]  a_value;
      logic [4:0]                 a_frac;
      logic [5:0]                 a_total;
      logic signed [VALUE_W-1:0]  b_value;
      logic [4:0]                 b_frac;
      logic [5:0]                 b_total;
      logic [4:0]                 dst_frac;
      logic [5:0]                 dst_total;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  result_value;
      logic [5:0]                 result_frac;
      logic [5:0]                 result_total;
   } rsp_type;

   typedef struct packed {
      logic       sat_mode;
      logic [5:0] width;
   } reduce_ctrl_type;

endpackage

`default_nettype wire

### src/fpau_reduce.sv
`default_nettype none

module fpau_reduce
   import fpau_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic signed [WIDE_W-1:0]     value,
   input  wire reduce_ctrl_type              ctrl,
   output logic signed [DATA_WIDTH-1:0]      result
);

   logic signed [WIDE_W-1:0]     half;
   logic signed [WIDE_W-1:0]     hi;
   logic signed [WIDE_W-1:0]     lo;
   logic [5:0]                   shamt;
   logic signed [DATA_WIDTH-1:0] low_bits;
   logic signed [DATA_WIDTH-1:0] shifted;
   logic signed [DATA_WIDTH-1:0] wrapped;

   always_comb begin
      half     = 64'sd1 <<< (ctrl.width - 6'd1);
      hi       = half - 64'sd1;
      lo       = -half;
      // Sign wrap keeps the low width bits and extends from the top one of them.
      shamt    = 6'(DATA_WIDTH) - ctrl.width;
      low_bits = value[DATA_WIDTH-1:0];
      shifted  = low_bits <<< shamt;
      wrapped  = shifted >>> shamt;
      if (ctrl.sat_mode) begin
         if (value > hi) begin
            result = hi[DATA_WIDTH-1:0];
         end else if (value < lo) begin
            result = lo[DATA_WIDTH-1:0];
         end else begin
            result = value[DATA_WIDTH-1:0];
         end
      end else begin
         result = wrapped;
      end
   end

endmodule

`default_nettype wire

### src/fixed_point_arith_unit_core.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_data (req_type)
// rsp_      out        rsp_valid/rsp_ready    rsp_data (rsp_type)
// csr_      in         csr_valid/csr_ready    csr_data (sat_mode)
//
// Three register stages: operand add, rounding add and 32x32 multiply; the
// alignment shift; saturation or wrap into the output register. One item is
// accepted every cycle unless rsp_ready stalls; the multiplier sets the first
// stage's depth. Reset clears the valid bits and sets sat_mode to wrap. A
// stall at rsp_ready holds each occupied stage, and bubbles still close up.
module fixed_point_arith_unit_core
   import fpau_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   function automatic logic [5:0] clamp_width(input logic [5:0] t);
      logic [5:0] w;
      w = t;
      if (t == 6'd0) begin
         w = 6'd1;
      end else if (t > 6'(DATA_WIDTH)) begin
         w = 6'(DATA_WIDTH);
      end
      return w;
   endfunction

   logic sat_mode_ff, sat_mode_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [WIDE_W-1:0] s1_value_ff, s1_value_in;
   logic [4:0]               s1_shift_ff, s1_shift_in;
   logic                     s1_left_ff, s1_left_in;
   logic [5:0]               s1_frac_ff, s1_frac_in;
   logic [5:0]               s1_total_ff, s1_total_in;

   logic                     s2_valid_ff, s2_valid_in;
   logic signed [WIDE_W-1:0] s2_value_ff, s2_value_in;
   logic [5:0]               s2_frac_ff, s2_frac_in;
   logic [5:0]               s2_total_ff, s2_total_in;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic adv1, adv2, adv3;

   logic signed [WIDE_W-1:0]     a_ext, b_ext, sum, prod, rnd;
   logic [5:0]                   at, bt, dt;
   logic [6:0]                   mul_total;
   logic [4:0]                   s_up, s_dn;
   reduce_ctrl_type              red_ctrl;
   logic signed [DATA_WIDTH-1:0] red_value;

   assign csr_ready   = 1'b1;
   assign sat_mode_in = csr_valid ? csr_data : sat_mode_ff;

   // Each stage moves on when it is empty or the stage after it moves on.
   assign adv3      = !out_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   // Stage one: operand adds, the multiply and the format bookkeeping.
   always_comb begin
      a_ext     = 64'(req_data.a_value);
      b_ext     = 64'(req_data.b_value);
      sum       = a_ext + b_ext;
      prod      = req_data.a_value * req_data.b_value;
      at        = clamp_width(req_data.a_total);
      bt        = clamp_width(req_data.b_total);
      dt        = clamp_width(req_data.dst_total);
      mul_total = 7'(at) + 7'(bt);
      s_up      = req_data.dst_frac - req_data.a_frac;
      s_dn      = req_data.a_frac - req_data.dst_frac;
      // Half an output LSB, taken away from zero by the sign of a.
      rnd       = 64'sd1 <<< (s_dn - 5'd1);
      if (req_data.a_value < 0) begin
         rnd = -rnd;
      end

      s1_valid_in = adv1 ? req_valid : s1_valid_ff;
      s1_value_in = '0;
      s1_shift_in = '0;
      s1_left_in  = 1'b0;
      s1_frac_in  = '0;
      s1_total_in = 6'd1;
      unique case (req_data.opcode)
         OP_ADD: begin
            s1_value_in = sum;
            s1_frac_in  = 6'(req_data.a_frac);
            s1_total_in = at;
         end
         OP_MUL: begin
            s1_value_in = prod;
            s1_frac_in  = 6'(req_data.a_frac) + 6'(req_data.b_frac);
            s1_total_in = (mul_total > 7'(DATA_WIDTH)) ? 6'(DATA_WIDTH) : mul_total[5:0];
         end
         OP_REQUANT: begin
            s1_frac_in  = 6'(req_data.dst_frac);
            s1_total_in = dt;
            if (req_data.dst_frac > req_data.a_frac) begin
               s1_value_in = a_ext;
               s1_shift_in = s_up;
               s1_left_in  = 1'b1;
            end else if (req_data.dst_frac < req_data.a_frac) begin
               s1_value_in = a_ext + rnd;
               s1_shift_in = s_dn;
            end else begin
               s1_value_in = a_ext;
            end
         end
         default: begin
         end
      endcase
   end

   // Stage two: alignment, exact left shift or floor right shift.
   always_comb begin
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s2_value_in = s1_left_ff ? (s1_value_ff <<< s1_shift_ff)
                               : (s1_value_ff >>> s1_shift_ff);
      s2_frac_in  = s1_frac_ff;
      s2_total_in = s1_total_ff;
   end

   // Stage three: reduction to the result width.
   assign red_ctrl = '{sat_mode: sat_mode_ff, width: s2_total_ff};

   fpau_reduce #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_reduce (
      .value  (s2_value_ff),
      .ctrl   (red_ctrl),
      .result (red_value)
   );

   always_comb begin
      out_valid_in             = adv3 ? s2_valid_ff : out_valid_ff;
      out_data_in.result_value = VALUE_W'(red_value);
      out_data_in.result_frac  = s2_frac_ff;
      out_data_in.result_total = s2_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_mode_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sat_mode_ff  <= sat_mode_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         s1_value_ff <= s1_value_in;
         s1_shift_ff <= s1_shift_in;
         s1_left_ff  <= s1_left_in;
         s1_frac_ff  <= s1_frac_in;
         s1_total_ff <= s1_total_in;
      end
      if (adv2 && s1_valid_ff) begin
         s2_value_ff <= s2_value_in;
         s2_frac_ff  <= s2_frac_in;
         s2_total_ff <= s2_total_in;
      end
      if (adv3 && s2_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
